[design/sha_pkg.sv]
// sha_pkg: shared types and constants for the sha-256 message hasher
// no dependencies

package sha_pkg;

  typedef struct packed {
    logic [31:0] data_word;
    logic [2:0]  byte_count;
    logic        end_of_message;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_item_t;

  // queue entry between front and back: one block word
  typedef struct packed {
    logic [31:0] word;
    logic        blk_end;   // sixteenth word of a block
    logic        msg_end;   // last word of the message
  } fb_item_t;

  localparam logic [31:0] IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam int unsigned BLOCK_BITS = 512;

  function automatic logic [31:0] round_k(input logic [5:0] i);
    logic [31:0] k [64];
    k = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };
    return k[i];
  endfunction

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage

[design/sha_front.sv]
// sha_front: packs message bytes into block words and appends the padding
// depends on sha_pkg

module sha_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  output logic              full_o,
  input  sha_pkg::in_item_t in_i,
  output logic              wr_o,
  output sha_pkg::fb_item_t wr_item_o,
  input  logic              wr_full_i
);

  typedef enum logic [3:0] {
    ST_IN   = 4'b0001,
    ST_PAD  = 4'b0010,
    ST_LENH = 4'b0100,
    ST_LENL = 4'b1000
  } fstate_e;

  localparam logic [7:0] PAD_BYTE_W = sha_pkg::PAD_BYTE;

  fstate_e     state_q, state_d;
  logic [5:0]  pos_q, pos_d;        // bytes held in the block
  logic [31:0] part_q, part_d;      // partly filled word
  logic [63:0] bits_q, bits_d;
  logic [2:0]  cnt;
  logic [63:0] merged;              // part word plus new bytes, plus overflow
  logic [2:0]  lane;
  logic [31:0] new_word;
  logic [6:0]  tot;

  assign cnt  = (in_i.byte_count > 3'd4) ? 3'd4 : in_i.byte_count;
  assign lane = {1'b0, pos_q[1:0]};

  always_comb begin
    logic [63:0] data64;
    data64 = {in_i.data_word, 32'h0};
    // mask invalid low bytes
    for (int b = 0; b < 4; b++) begin
      if (3'(b) >= cnt) data64[63-8*b -: 8] = 8'h0;
    end
    merged = {part_q, 32'h0} | (data64 >> (8 * lane));
  end

  assign tot = {1'b0, pos_q} + {4'd0, cnt};

  always_comb begin
    state_d  = state_q;
    pos_d    = pos_q;
    part_d   = part_q;
    bits_d   = bits_q;
    wr_o     = 1'b0;
    wr_item_o = '{word: '0, blk_end: 1'b0, msg_end: 1'b0};
    new_word = '0;
    full_o   = 1'b1;
    unique case (state_q)
      ST_IN: begin
        full_o = wr_full_i;
        if (push_i && !wr_full_i) begin
          bits_d = bits_q + {58'd0, cnt, 3'd0};
          pos_d  = tot[5:0];
          if (tot[6:2] != {1'b0, pos_q[5:2]}) begin
            // a word completed
            wr_o = 1'b1;
            wr_item_o.word = merged[63:32];
            wr_item_o.blk_end = (pos_q[5:2] == 4'd15);
            part_d = merged[31:0];
          end else begin
            part_d = merged[63:32];
          end
          if (in_i.end_of_message) begin
            // append the marker byte into the current word
            new_word = (pos_d[1:0] == 2'd0) ? 32'h0 : part_d;
            part_d = new_word | ({PAD_BYTE_W, 24'h0} >> (8 * pos_d[1:0]));
            pos_d  = {pos_d[5:2], 2'd0} + 6'd4;
            state_d = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        // flush the word holding the marker, then zero words up to word 13
        if (!wr_full_i) begin
          wr_o = 1'b1;
          wr_item_o.word = part_q;
          wr_item_o.blk_end = (pos_q == 6'd0);
          part_d = '0;
          if (pos_q == 6'd56) state_d = ST_LENH;
          pos_d = pos_q + 6'd4;
        end
      end
      ST_LENH: begin
        if (!wr_full_i) begin
          wr_o = 1'b1;
          wr_item_o.word = bits_q[63:32];
          state_d = ST_LENL;
        end
      end
      default: begin
        if (!wr_full_i) begin
          wr_o = 1'b1;
          wr_item_o = '{word: bits_q[31:0], blk_end: 1'b1, msg_end: 1'b1};
          state_d = ST_IN;
          pos_d   = '0;
          bits_d  = '0;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IN;
      pos_q   <= '0;
      bits_q  <= '0;
      part_q  <= '0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      bits_q  <= bits_d;
      part_q  <= part_d;
    end
  end

endmodule

[design/sha_queue.sv]
// sha_queue: small fifo of block words between front and back
// depends on sha_pkg

module sha_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_i,
  input  sha_pkg::fb_item_t wr_item_i,
  output logic              full_o,
  input  logic              rd_i,
  output sha_pkg::fb_item_t rd_item_o,
  output logic              empty_o
);

  localparam int unsigned AW = $clog2(DEPTH);

  sha_pkg::fb_item_t mem_q [DEPTH];
  logic [AW-1:0] wp_q, rp_q;
  logic [AW:0]   cnt_q;

  assign full_o    = (cnt_q == (AW+1)'(DEPTH));
  assign empty_o   = (cnt_q == '0);
  assign rd_item_o = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (wr_i) wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
      if (rd_i) rp_q <= (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
      cnt_q <= cnt_q + (AW+1)'(wr_i) - (AW+1)'(rd_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) mem_q[wp_q] <= wr_item_i;
  end

endmodule

[design/sha_core.sv]
// sha_core: message schedule, 64 rounds one per cycle, chaining and digest output
// depends on sha_pkg

module sha_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_empty_i,
  input  sha_pkg::fb_item_t  q_item_i,
  output logic               q_rd_o,
  output logic               empty_o,
  input  logic               pop_i,
  output sha_pkg::out_item_t out_o
);

  typedef enum logic [3:0] {
    ST_LOAD = 4'b0001,
    ST_RUN  = 4'b0010,
    ST_ADD  = 4'b0100,
    ST_OUT  = 4'b1000
  } cstate_e;

  cstate_e     state_q, state_d;
  logic [31:0] w_q [16];
  logic [31:0] v_q [8];
  logic [31:0] h_q [8];
  logic [5:0]  rnd_q;
  logic [2:0]  oidx_q;
  logic        msg_q;
  logic [31:0] w_new, t1, t2, wt;

  always_comb begin
    logic [31:0] s0, s1, e, a;
    s0 = sha_pkg::rotr(w_q[1], 7) ^ sha_pkg::rotr(w_q[1], 18) ^ (w_q[1] >> 3);
    s1 = sha_pkg::rotr(w_q[14], 17) ^ sha_pkg::rotr(w_q[14], 19) ^ (w_q[14] >> 10);
    w_new = s1 + w_q[9] + s0 + w_q[0];
    wt = w_q[0];
    e = v_q[4];
    a = v_q[0];
    t1 = v_q[7] + (sha_pkg::rotr(e, 6) ^ sha_pkg::rotr(e, 11) ^ sha_pkg::rotr(e, 25))
       + ((e & v_q[5]) ^ (~e & v_q[6])) + sha_pkg::round_k(rnd_q) + wt;
    t2 = (sha_pkg::rotr(a, 2) ^ sha_pkg::rotr(a, 13) ^ sha_pkg::rotr(a, 22))
       + ((a & v_q[1]) ^ (a & v_q[2]) ^ (v_q[1] & v_q[2]));
  end

  assign q_rd_o  = (state_q == ST_LOAD) && !q_empty_i;
  assign empty_o = (state_q != ST_OUT);
  assign out_o   = '{digest_word: h_q[oidx_q], word_index: oidx_q,
                     last_word: (oidx_q == 3'd7)};

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_LOAD: if (q_rd_o && q_item_i.blk_end) state_d = ST_RUN;
      ST_RUN:  if (rnd_q == 6'd63) state_d = ST_ADD;
      ST_ADD:  state_d = msg_q ? ST_OUT : ST_LOAD;
      default: if (pop_i && oidx_q == 3'd7) state_d = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      rnd_q   <= '0;
      oidx_q  <= '0;
      msg_q   <= 1'b0;
      for (int i = 0; i < 8; i++) begin
        h_q[i] <= sha_pkg::IV[i];
        v_q[i] <= sha_pkg::IV[i];
      end
    end else begin
      state_q <= state_d;
      unique case (state_q)
        ST_LOAD: begin
          if (q_rd_o) msg_q <= q_item_i.msg_end;
          for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
          rnd_q <= '0;
        end
        ST_RUN: begin
          v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4];
          v_q[4] <= v_q[3] + t1;
          v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0];
          v_q[0] <= t1 + t2;
          rnd_q  <= rnd_q + 6'd1;
        end
        ST_ADD: begin
          for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
          oidx_q <= '0;
        end
        default: begin
          if (pop_i) begin
            oidx_q <= oidx_q + 3'd1;
            if (oidx_q == 3'd7) begin
              for (int i = 0; i < 8; i++) h_q[i] <= sha_pkg::IV[i];
            end
          end
        end
      endcase
    end
  end

  // schedule window: shifts on load and on every round
  always_ff @(posedge clk_i) begin
    if (q_rd_o || state_q == ST_RUN) begin
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
      w_q[15] <= q_rd_o ? q_item_i.word : w_new;
    end
  end

endmodule

[design/sha256_message_hasher_top.sv]
// sha256_message_hasher_top: sha-256 hasher with queue style channels
// depends on sha_pkg, sha_front, sha_queue, sha_core
//
// usage:
//   input channel: push / full carry one transaction per message word
//   (big-endian data, 0..4 valid leading bytes, end flag). the front packs
//   bytes into 32-bit block words, appends the 0x80 marker, zero fill and the
//   64-bit bit length, and writes words to a short queue.
//   the core takes 16 words from the queue (one per cycle while the queue
//   is not empty), runs 64 rounds one per cycle, then adds into the
//   chaining value; it takes no words while it runs and adds, so the block
//   rate is set by the single round unit of the core.
//   result channel: empty / pop; after the final block, eight
//   transactions appear in order, word_index 0..7, last_word on the eighth.
//   the first digest word follows the end-of-message transaction once the
//   padding words and one or two compressions are done.
//   if the receiver stalls, the core holds the digest and stops taking words;
//   the queue fills and full rises, so the sender stalls in turn.
//   reset: chaining value goes to the standard iv, byte and bit counts clear,
//   the queue empties; block word storage is not cleared

module sha256_message_hasher_top #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  sha_pkg::in_item_t  in_item_i,
  output logic               empty,
  input  logic               pop,
  output sha_pkg::out_item_t out_item_o
);

  logic              q_wr, q_full, q_rd, q_empty;
  sha_pkg::fb_item_t q_wr_item, q_rd_item;

  // front: byte packing and padding
  sha_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .full_o    (full),
    .in_i      (in_item_i),
    .wr_o      (q_wr),
    .wr_item_o (q_wr_item),
    .wr_full_i (q_full)
  );

  // decoupling queue of block words
  sha_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (q_wr),
    .wr_item_i (q_wr_item),
    .full_o    (q_full),
    .rd_i      (q_rd),
    .rd_item_o (q_rd_item),
    .empty_o   (q_empty)
  );

  // back: compression and digest output
  sha_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .q_item_i  (q_rd_item),
    .q_rd_o    (q_rd),
    .empty_o   (empty),
    .pop_i     (pop),
    .out_o     (out_item_o)
  );

endmodule

[design/sha_checker.sv]
// sha_checker: port level checks for sha256_message_hasher_top
// depends on sha_pkg; bound to the top level below

module sha_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               empty,
  input logic               pop,
  input sha_pkg::out_item_t out_item_o
);

  // a waiting result holds while not taken
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(out_item_o))
    else $error("result changed while stalled");

  // last_word flags index seven only
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (out_item_o.last_word == (out_item_o.word_index == 3'd7)))
    else $error("last_word mismatch");

  // indices step by one within a digest
  a_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && pop && !out_item_o.last_word |=>
      !empty && out_item_o.word_index == $past(out_item_o.word_index) + 3'd1)
    else $error("digest word order broken");

  // no result is offered when reset is released
  a_reset: assert property (@(posedge clk_i) $rose(rst_ni) |-> empty)
    else $error("result after reset");

endmodule

bind sha256_message_hasher_top sha_checker u_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .empty      (empty),
  .pop        (pop),
  .out_item_o (out_item_o)
);
